### rtl/core/anbs_pkg.sv
`timescale 1ns / 1ps

package anbs_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [1:0] MIN_ZEROS = 2'd2;
    localparam logic [1:0] MAX_HELD  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_NO_START  = 2'd2;
    localparam logic [1:0] ST_UNTERM    = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_UNIT   = 2'd1,
        PH_ERROR  = 2'd2
    } t_phase;

    // One input byte's worth of results, in this order:
    // zero payload bytes, data payload byte, mid-stream close, tail result.
    typedef struct packed {
        logic [2:0] nzero;
        logic       has_data;
        logic [7:0] data;
        logic       first;
        logic       mid_close;
        logic       has_tail;
        logic       tail_end;
        logic [1:0] tail_status;
    } t_cmd;

endpackage

### rtl/core/anbs_front.sv
`timescale 1ns / 1ps

module anbs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    input  logic               i_q_full,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_data,
    output logic               o_accept,
    output logic               o_push,
    output anbs_pkg::t_cmd     o_cmd
);

    anbs_pkg::t_phase r_phase, n_phase;
    logic [1:0]       r_hzc, n_hzc;
    logic [1:0]       r_held, n_held;
    logic             r_has, n_has;
    logic             r_fp, n_fp;
    logic             r_ecu;

    anbs_pkg::t_cmd   cmd;
    logic [2:0]       z1;
    logic [2:0]       z2;
    logic [1:0]       held_s;
    logic             has_s;
    logic             fp_s;

    assign o_accept = i_valid && !i_q_full;
    assign o_cmd    = cmd;
    assign o_push   = o_accept && ((cmd.nzero != 3'd0) || cmd.has_data || cmd.mid_close
                                   || cmd.has_tail);

    always_comb begin
        n_phase = r_phase;
        n_hzc   = r_hzc;
        n_held  = r_held;
        n_has   = r_has;
        n_fp    = r_fp;
        cmd     = '0;
        z1      = 3'd0;
        z2      = 3'd0;
        held_s  = r_held;
        has_s   = r_has;
        fp_s    = r_fp;
        cmd.data  = i_data_byte;
        cmd.first = r_fp;

        case (r_phase)
            anbs_pkg::PH_HEADER: begin
                if (i_data_byte == anbs_pkg::BYTE_ZERO) begin
                    if (r_hzc < anbs_pkg::MIN_ZEROS) begin
                        n_hzc = r_hzc + 2'd1;
                    end
                    if (i_last_byte) begin
                        cmd.has_tail    = 1'b1;
                        cmd.tail_status = anbs_pkg::ST_NO_START;
                    end
                end else if (i_data_byte == anbs_pkg::BYTE_ONE
                             && r_hzc >= anbs_pkg::MIN_ZEROS) begin
                    n_phase = anbs_pkg::PH_UNIT;
                    n_held  = 2'd0;
                    n_has   = 1'b0;
                    n_fp    = 1'b1;
                    if (i_last_byte) begin
                        cmd.has_tail    = 1'b1;
                        cmd.tail_end    = 1'b1;
                        cmd.tail_status = r_ecu ? anbs_pkg::ST_OK : anbs_pkg::ST_UNTERM;
                    end
                end else begin
                    cmd.has_tail    = 1'b1;
                    cmd.tail_status = anbs_pkg::ST_MALFORMED;
                    n_phase         = anbs_pkg::PH_ERROR;
                end
            end
            anbs_pkg::PH_UNIT: begin
                if (i_data_byte == anbs_pkg::BYTE_ZERO) begin
                    if (r_held == anbs_pkg::MAX_HELD) begin
                        // release the oldest held zero
                        z1    = 3'd1;
                        has_s = 1'b1;
                        fp_s  = 1'b0;
                    end else begin
                        held_s = r_held + 2'd1;
                    end
                end else if (i_data_byte == anbs_pkg::BYTE_ONE
                             && r_held >= anbs_pkg::MIN_ZEROS) begin
                    z1            = {2'b00, (r_held == anbs_pkg::MAX_HELD) && !r_has};
                    cmd.mid_close = 1'b1;
                    held_s        = 2'd0;
                    has_s         = 1'b0;
                    fp_s          = 1'b1;
                end else begin
                    z1           = {1'b0, r_held};
                    cmd.has_data = 1'b1;
                    held_s       = 2'd0;
                    has_s        = 1'b1;
                    fp_s         = 1'b0;
                end
                n_held = held_s;
                n_has  = has_s;
                n_fp   = fp_s;
                if (i_last_byte) begin
                    // flush held zeros, stripping the final one when allowed;
                    // two or more held zeros put a payload byte ahead of the last
                    if (held_s != 2'd0) begin
                        z2 = {1'b0, held_s} - 3'd1
                             + {2'b00, !(r_ecu && (has_s
                                                   || held_s >= anbs_pkg::MIN_ZEROS))};
                    end
                    cmd.has_tail    = 1'b1;
                    cmd.tail_end    = 1'b1;
                    cmd.tail_status = r_ecu ? anbs_pkg::ST_OK : anbs_pkg::ST_UNTERM;
                end
                cmd.nzero = z1 + z2;
            end
            default: begin
                n_phase = anbs_pkg::PH_ERROR;
            end
        endcase

        if (i_last_byte) begin
            n_phase = anbs_pkg::PH_HEADER;
            n_hzc   = 2'd0;
            n_held  = 2'd0;
            n_has   = 1'b0;
            n_fp    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= anbs_pkg::PH_HEADER;
            r_hzc   <= 2'd0;
            r_held  <= 2'd0;
            r_has   <= 1'b0;
            r_fp    <= 1'b1;
            r_ecu   <= 1'b1;
        end else begin
            if (o_accept) begin
                r_phase <= n_phase;
                r_hzc   <= n_hzc;
                r_held  <= n_held;
                r_has   <= n_has;
                r_fp    <= n_fp;
            end
            if (i_cfg_valid) begin
                r_ecu <= i_cfg_data;
            end
        end
    end

endmodule

### rtl/core/anbs_queue.sv
`timescale 1ns / 1ps

module anbs_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  anbs_pkg::t_cmd     i_cmd,
    input  logic               i_pop,
    output anbs_pkg::t_cmd     o_head,
    output logic               o_empty,
    output logic               o_full
);

    anbs_pkg::t_cmd              r_mem [anbs_pkg::QDEPTH];
    logic [anbs_pkg::QAW-1:0]    r_wp;
    logic [anbs_pkg::QAW-1:0]    r_rp;
    logic [anbs_pkg::QAW:0]      r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (anbs_pkg::QAW + 1)'(anbs_pkg::QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/core/anbs_back.sv
`timescale 1ns / 1ps

module anbs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  anbs_pkg::t_cmd     i_head,
    input  logic               i_empty,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_byte_valid,
    output logic               o_first_of_unit,
    output logic               o_end_of_unit,
    output logic [1:0]         o_status,
    output logic               o_last_result
);

    logic             r_busy;
    anbs_pkg::t_cmd   r_work;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_bvalid;
    logic             r_first;
    logic             r_end;
    logic [1:0]       r_status;
    logic             r_last;

    anbs_pkg::t_cmd   eff;
    anbs_pkg::t_cmd   rem;
    logic             eff_valid;
    logic             load;
    logic             rem_empty;
    logic [7:0]       n_byte;
    logic             n_bvalid;
    logic             n_first;
    logic             n_end;
    logic [1:0]       n_status;

    assign eff       = r_busy ? r_work : i_head;
    assign eff_valid = r_busy || !i_empty;
    assign load      = eff_valid && (!r_valid || !i_stall);
    assign o_pop     = load && !r_busy;

    // Emit the next result of the current beat and keep what remains.
    always_comb begin
        rem      = eff;
        n_byte   = 8'h00;
        n_bvalid = 1'b0;
        n_first  = 1'b0;
        n_end    = 1'b0;
        n_status = anbs_pkg::ST_OK;
        if (eff.nzero != 3'd0) begin
            n_bvalid  = 1'b1;
            n_first   = eff.first;
            rem.nzero = eff.nzero - 3'd1;
            rem.first = 1'b0;
        end else if (eff.has_data) begin
            n_byte       = eff.data;
            n_bvalid     = 1'b1;
            n_first      = eff.first;
            rem.has_data = 1'b0;
            rem.first    = 1'b0;
        end else if (eff.mid_close) begin
            n_end         = 1'b1;
            rem.mid_close = 1'b0;
        end else begin
            n_end        = eff.tail_end;
            n_status     = eff.tail_status;
            rem.has_tail = 1'b0;
        end
        rem_empty = (rem.nzero == 3'd0) && !rem.has_data && !rem.mid_close && !rem.has_tail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy  <= !rem_empty;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_work   <= rem;
            r_byte   <= n_byte;
            r_bvalid <= n_bvalid;
            r_first  <= n_first;
            r_end    <= n_end;
            r_status <= n_status;
            r_last   <= rem_empty;
        end
    end

    assign o_valid         = r_valid;
    assign o_out_byte      = r_byte;
    assign o_byte_valid    = r_bvalid;
    assign o_first_of_unit = r_first;
    assign o_end_of_unit   = r_end;
    assign o_status        = r_status;
    assign o_last_result   = r_last;

endmodule

### rtl/core/annexb_nal_unit_splitter_core.sv
`timescale 1ns / 1ps

// An accepted byte's results pass through the queue and then the output register.
// Throughput: one byte per cycle while o_stall is low and each byte yields at most one
// result; a byte yielding k results (up to five) holds the output register until all k
// are out; a four-entry queue between classifier and result generator absorbs bursts.
// Reset (i_rst_n low, synchronous): header search, queue empty, end_closes_unit = 1.
module annexb_nal_unit_splitter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_stall,
    output logic        o_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_first_of_unit,
    output logic        o_end_of_unit,
    output logic [1:0]  o_status,
    output logic        o_last_result,
    input  logic        i_stall,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_data,
    output logic        o_cfg_ready
);

    anbs_pkg::t_cmd cmd;
    anbs_pkg::t_cmd head;
    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;
    logic           accept;

    assign o_stall     = q_full;
    assign o_cfg_ready = 1'b1;

    anbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (q_full),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_accept    (accept),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    anbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && accept),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    anbs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_empty         (q_empty),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_first_of_unit (o_first_of_unit),
        .o_end_of_unit   (o_end_of_unit),
        .o_status        (o_status),
        .o_last_result   (o_last_result)
    );

endmodule
